/* hdl/bsfr_pkg.sv */
// Shared types and constants for the byte-stuffed frame receiver.
package bsfr_pkg;

  localparam logic [7:0] BYTE_START  = 8'hFF;
  localparam logic [7:0] BYTE_END    = 8'hFE;
  localparam logic [7:0] BYTE_ESCAPE = 8'hFD;
  localparam logic [7:0] ESCAPE_BIT  = 8'h80;

  localparam logic [7:0] MAX_LEN_RESET = 8'hFF;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_GOOD  = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    TOK_DATA,
    TOK_START,
    TOK_END,
    TOK_ESCAPE
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] value;
  } token_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_ESC  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                not_empty;
    logic                full;
    logic [QUEUE_CW-1:0] count;
  } queue_status_t;

endpackage

/* hdl/bsfr_front.sv */
// Front end: accepts wire bytes and classifies them into tokens for the queue.
module bsfr_front (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             wire_byte,
  input  bsfr_pkg::queue_status_t q_status,
  output logic                   push,
  output bsfr_pkg::token_t       push_token
);

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_token.value = wire_byte;
    priority if (wire_byte == bsfr_pkg::BYTE_START) begin
      push_token.kind = bsfr_pkg::TOK_START;
    end else if (wire_byte == bsfr_pkg::BYTE_END) begin
      push_token.kind = bsfr_pkg::TOK_END;
    end else if (wire_byte == bsfr_pkg::BYTE_ESCAPE) begin
      push_token.kind = bsfr_pkg::TOK_ESCAPE;
    end else begin
      push_token.kind = bsfr_pkg::TOK_DATA;
    end
  end

endmodule

/* hdl/bsfr_queue.sv */
// Short token queue between the front end and the frame engine.
module bsfr_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  bsfr_pkg::token_t        push_token,
  input  logic                    pop,
  output bsfr_pkg::token_t        head,
  output bsfr_pkg::queue_status_t q_status
);

  bsfr_pkg::token_t                entries [bsfr_pkg::QUEUE_DEPTH];
  logic [bsfr_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [bsfr_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [bsfr_pkg::QUEUE_CW-1:0]  count;

  localparam logic [bsfr_pkg::QUEUE_CW-1:0] DEPTH_C = bsfr_pkg::QUEUE_CW'(bsfr_pkg::QUEUE_DEPTH);

  assign head               = entries[rd_ptr];
  assign q_status.not_empty = (count != '0);
  assign q_status.full      = (count == DEPTH_C);
  assign q_status.count     = count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/bsfr_back.sv */
// Frame engine: runs the receive phases on tokens and holds the result register.
module bsfr_back (
  input  logic             clk,
  input  logic             rst,
  input  bsfr_pkg::token_t head,
  input  logic             head_valid,
  input  logic [7:0]       max_frame_length,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [7:0]       payload_length
);

  bsfr_pkg::phase_t phase;
  bsfr_pkg::phase_t phase_next;
  logic [7:0]       byte_count;
  logic [7:0]       byte_count_next;
  logic [7:0]       running_sum;
  logic [7:0]       running_sum_next;

  logic       take;
  logic       limit_hit;
  logic       frame_good;
  logic [7:0] dval;
  logic       emit;
  logic [1:0] res_kind;
  logic [7:0] res_data;
  logic [7:0] res_len;

  assign take       = head_valid && (!out_valid || out_ready);
  assign pop        = take;
  assign limit_hit  = (byte_count >= max_frame_length);
  assign frame_good = (byte_count != 8'd0) && (running_sum == 8'd0);
  assign dval       = (phase == bsfr_pkg::PH_ESC) ? (head.value | bsfr_pkg::ESCAPE_BIT)
                                                   : head.value;

  // Next phase, count and sum.
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    unique case (phase)
      bsfr_pkg::PH_RECV, bsfr_pkg::PH_ESC: begin
        unique case (head.kind)
          bsfr_pkg::TOK_START: begin
            phase_next       = bsfr_pkg::PH_RECV;
            byte_count_next  = 8'd0;
            running_sum_next = 8'd0;
          end
          bsfr_pkg::TOK_END: begin
            phase_next = bsfr_pkg::PH_IDLE;
          end
          bsfr_pkg::TOK_ESCAPE: begin
            phase_next = (phase == bsfr_pkg::PH_RECV) ? bsfr_pkg::PH_ESC : bsfr_pkg::PH_IDLE;
          end
          bsfr_pkg::TOK_DATA: begin
            if (limit_hit) begin
              phase_next = bsfr_pkg::PH_IDLE;
            end else begin
              phase_next       = bsfr_pkg::PH_RECV;
              byte_count_next  = byte_count + 8'd1;
              running_sum_next = running_sum + dval;
            end
          end
          default: phase_next = bsfr_pkg::PH_IDLE;
        endcase
      end
      default: begin
        // Idle, and the unused code, wait for a start byte.
        if (head.kind == bsfr_pkg::TOK_START) begin
          phase_next       = bsfr_pkg::PH_RECV;
          byte_count_next  = 8'd0;
          running_sum_next = 8'd0;
        end else begin
          phase_next = bsfr_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // Result produced by the head token.
  always_comb begin
    emit     = 1'b0;
    res_kind = bsfr_pkg::KIND_DATA;
    res_data = 8'd0;
    res_len  = 8'd0;
    unique case (phase)
      bsfr_pkg::PH_RECV, bsfr_pkg::PH_ESC: begin
        unique case (head.kind)
          bsfr_pkg::TOK_START: begin
            emit     = 1'b1;
            res_kind = bsfr_pkg::KIND_ABORT;
          end
          bsfr_pkg::TOK_END: begin
            emit = 1'b1;
            if (phase == bsfr_pkg::PH_ESC) begin
              res_kind = bsfr_pkg::KIND_ABORT;
            end else if (frame_good) begin
              res_kind = bsfr_pkg::KIND_GOOD;
              res_len  = byte_count - 8'd1;
            end else begin
              res_kind = bsfr_pkg::KIND_BAD;
            end
          end
          bsfr_pkg::TOK_ESCAPE: begin
            emit     = (phase == bsfr_pkg::PH_ESC);
            res_kind = bsfr_pkg::KIND_ABORT;
          end
          bsfr_pkg::TOK_DATA: begin
            emit = 1'b1;
            if (limit_hit) begin
              res_kind = bsfr_pkg::KIND_ABORT;
            end else begin
              res_kind = bsfr_pkg::KIND_DATA;
              res_data = dval;
            end
          end
          default: emit = 1'b0;
        endcase
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= bsfr_pkg::PH_IDLE;
      byte_count  <= 8'd0;
      running_sum <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        phase       <= phase_next;
        byte_count  <= byte_count_next;
        running_sum <= running_sum_next;
        out_valid   <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind           <= res_kind;
      data_byte      <= res_data;
      payload_length <= res_len;
    end
  end

endmodule

/* hdl/byte_stuffed_frame_receiver_top.sv */
// Top level of the byte-stuffed frame receiver with additive checksum.
//
// The input channel (in_valid, in_ready, wire_byte) takes one raw wire byte
// per beat. Byte 255 opens or restarts a frame, 254 closes it and 253 escapes
// the next byte, which then decodes as that byte OR 0x80.
// The output channel (out_valid, out_ready, kind, data_byte, payload_length)
// gives at most one beat per input beat: a decoded data byte, a good or bad
// frame end, or an abort. A first escape byte and bytes outside a frame give none.
// An accepted byte is written into the queue, and the frame engine registers
// its result. Throughput is one byte per cycle while out_ready is high, set by
// the frame engine, which then retires one queued token per cycle.
// The front end classifies bytes into a four-entry token queue; when the
// receiver holds out_ready low the result register holds, the queue fills,
// and in_ready drops only once the queue is full.
// cfg_write_en with cfg_write_data sets the frame length limit at once.
// Synchronous reset empties the queue, clears out_valid, returns
// to idle awaiting a start byte, and sets the limit to 255.
module byte_stuffed_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] wire_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [7:0] payload_length
);

  // Frame length limit, counted in decoded bytes with the checksum byte.
  logic [7:0] max_frame_length;

  bsfr_pkg::queue_status_t q_status;
  bsfr_pkg::token_t        push_token;
  bsfr_pkg::token_t        head;
  logic                    push;
  logic                    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= bsfr_pkg::MAX_LEN_RESET;
    end else if (cfg_write_en) begin
      max_frame_length <= cfg_write_data;
    end
  end

  bsfr_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .wire_byte  (wire_byte),
    .q_status   (q_status),
    .push       (push),
    .push_token (push_token)
  );

  bsfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  bsfr_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .head_valid       (q_status.not_empty),
    .max_frame_length (max_frame_length),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .data_byte        (data_byte),
    .payload_length   (payload_length)
  );

  // Only data beats carry a decoded byte.
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != bsfr_pkg::KIND_DATA) |-> data_byte == 8'd0)
    else $error("data_byte nonzero on a non-data beat");

  // Only a good frame end carries a length.
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != bsfr_pkg::KIND_GOOD) |-> payload_length == 8'd0)
    else $error("payload_length nonzero on a beat other than good end");

  // A push without a pop grows the queue by exactly one token.
  a_queue_grow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> q_status.count == $past(q_status.count) + 1'b1)
    else $error("queue count did not follow a push");

  // A new output beat only appears after the engine retired a token.
  a_out_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop))
    else $error("output beat without a retired token");

endmodule

/* tb/tb_byte_stuffed_frame_receiver_top.sv */
// Self-checking testbench for the byte-stuffed frame receiver.
module tb_byte_stuffed_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfr_pkg::*;

  // Cycles to let the token queue and the frame engine settle when no result
  // is pending. Escapes and idle bytes give no beat, so an empty expectation
  // queue does not yet mean the pipeline is empty.
  localparam int SETTLE_CYCLES = 12;

  // One decoded beat on the output channel.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] plen;
  } rx_beat_t;

  // Tracks the receiver state on every accepted wire byte, queues the beat
  // that byte must produce, and checks the output beats in order.
  class frame_scoreboard;
    phase_t     phase;
    logic [7:0] count;
    logic [7:0] sum;
    logic [7:0] limit;
    rx_beat_t   beat_q[$];
    int         errors;
    int         frame_bytes;

    function new();
      phase       = PH_IDLE;
      count       = '0;
      sum         = '0;
      limit       = MAX_LEN_RESET;
      errors      = 0;
      frame_bytes = 0;
    endfunction

    function void set_limit(logic [7:0] value);
      limit = value;
    endfunction

    function int outstanding();
      return beat_q.size();
    endfunction

    function void push_beat(logic [1:0] k, logic [7:0] d, logic [7:0] l);
      rx_beat_t b;
      b.kind = k;
      b.data = d;
      b.plen = l;
      beat_q.push_back(b);
    endfunction

    function void open_frame();
      phase = PH_RECV;
      count = '0;
      sum   = '0;
    endfunction

    // A decoded byte either lands in the frame or trips the length limit.
    function void take_byte(logic [7:0] value);
      if (count >= limit) begin
        phase = PH_IDLE;
        push_beat(KIND_ABORT, 8'd0, 8'd0);
      end else begin
        count = count + 8'd1;
        sum   = sum + value;
        phase = PH_RECV;
        push_beat(KIND_DATA, value, 8'd0);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      if (phase != PH_IDLE || b == BYTE_START) frame_bytes++;
      case (phase)
        PH_RECV: begin
          if (b == BYTE_ESCAPE) begin
            phase = PH_ESC;
          end else if (b == BYTE_START) begin
            open_frame();
            push_beat(KIND_ABORT, 8'd0, 8'd0);
          end else if (b == BYTE_END) begin
            phase = PH_IDLE;
            if (count != 8'd0 && sum == 8'd0) push_beat(KIND_GOOD, 8'd0, count - 8'd1);
            else push_beat(KIND_BAD, 8'd0, 8'd0);
          end else begin
            take_byte(b);
          end
        end
        PH_ESC: begin
          if (b == BYTE_START) begin
            open_frame();
            push_beat(KIND_ABORT, 8'd0, 8'd0);
          end else if (b >= BYTE_ESCAPE) begin
            phase = PH_IDLE;
            push_beat(KIND_ABORT, 8'd0, 8'd0);
          end else begin
            take_byte(b | ESCAPE_BIT);
          end
        end
        default: begin
          phase = PH_IDLE;
          if (b == BYTE_START) open_frame();
        end
      endcase
    endfunction

    function void check_beat(logic [1:0] k, logic [7:0] d, logic [7:0] l);
      rx_beat_t exp_beat;
      if (beat_q.size() == 0) begin
        $error("unexpected beat: kind %0d data_byte 0x%02h payload_length %0d", k, d, l);
        errors++;
        return;
      end
      exp_beat = beat_q.pop_front();
      if (k !== exp_beat.kind) begin
        $error("kind: expected %0d, got %0d", exp_beat.kind, k);
        errors++;
      end
      if (d !== exp_beat.data) begin
        $error("data_byte: expected 0x%02h, got 0x%02h", exp_beat.data, d);
        errors++;
      end
      if (l !== exp_beat.plen) begin
        $error("payload_length: expected %0d, got %0d", exp_beat.plen, l);
        errors++;
      end
    endfunction
  endclass

  // Block ports. Every input holds a known value from time zero.
  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       cfg_write_en   = 1'b0;
  logic [7:0] cfg_write_data = 8'd0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] wire_byte      = 8'd0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] payload_length;

  frame_scoreboard sb = new();

  // Upper bound of the random wait drawn per beat on each side. A phase sets
  // both to zero to get stretches of full-rate traffic.
  int in_gap_max  = 4;
  int out_gap_max = 4;
  int rx_wait     = 0;

  byte_stuffed_frame_receiver_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .wire_byte      (wire_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .payload_length (payload_length)
  );

  always #5 clk = ~clk;

  // Sampling happens at the rising edge, ahead of any register update, so the
  // values seen are the ones the block itself saw at that edge. A byte
  // accepted at this edge cannot produce a beat at the same edge, so noting
  // it before checking keeps the expectation order intact.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_byte(wire_byte);
    if (!rst && out_valid && out_ready) begin
      sb.check_beat(kind, data_byte, payload_length);
      rx_wait = $urandom_range(0, out_gap_max);
    end
  end

  // The receiving side holds off for the drawn number of cycles after each
  // beat it takes, then stays ready until the next beat arrives.
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one wire byte after a random gap and returns once it is accepted.
  // Valid stays high after acceptance so that back-to-back bytes never see a
  // low-then-high pair in the same time step; the next call with a gap, or quiesce(), lowers it.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    wire_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_list(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Stuffs one decoded byte. The three marker values must be escaped; other
  // bytes with the top bit set may go either way on the wire.
  task automatic send_stuffed(logic [7:0] b);
    if (b >= BYTE_ESCAPE || (b[7] && $urandom_range(0, 1) == 1)) begin
      send_byte(BYTE_ESCAPE);
      send_byte(b & ~ESCAPE_BIT);
    end else begin
      send_byte(b);
    end
  endtask

  // Sends a start marker and n decoded bytes whose last byte is the checksum,
  // correct or deliberately off, and optionally the end marker.
  task automatic send_frame(int n, bit sum_ok, bit closed);
    logic [7:0] body[$];
    logic [7:0] acc;
    logic [7:0] b;
    acc = 8'd0;
    for (int i = 0; i < n - 1; i++) begin
      b = 8'($urandom_range(0, 255));
      body.push_back(b);
      acc = acc + b;
    end
    if (n > 0) begin
      b = 8'd0 - acc;
      if (!sum_ok) b = b + 8'($urandom_range(1, 255));
      body.push_back(b);
    end
    send_byte(BYTE_START);
    foreach (body[i]) send_stuffed(body[i]);
    if (closed) send_byte(BYTE_END);
  endtask

  // Drops valid, waits for every expected beat, then lets the pipeline drain
  // bytes that produce no beat.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The limit register is only changed with the block idle.
  task automatic write_limit(logic [7:0] value);
    quiesce();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    sb.set_limit(value);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // One random chunk of traffic. Most of it is well-formed frames with random
  // content; the rest is bad checksums, frames cut short by a restart, escape
  // errors and line noise between frames.
  task automatic random_chunk(int lim);
    int pick;
    int n;
    if ((lim <= 32 && $urandom_range(0, 9) == 0) || $urandom_range(0, 99) == 0)
      n = lim + $urandom_range(0, 1);
    else
      n = $urandom_range(0, (lim < 14) ? lim + 2 : 16);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      send_frame(n, 1'b1, 1'b1);
    end else if (pick < 72) begin
      send_frame(n, 1'b0, 1'b1);
    end else if (pick < 80) begin
      // Left open: the next start marker restarts it.
      send_frame(n, 1'b1, 1'b0);
    end else if (pick < 88) begin
      send_frame(n, 1'b1, 1'b0);
      send_byte(BYTE_ESCAPE);
      send_byte($urandom_range(0, 1) ? BYTE_END : BYTE_ESCAPE);
    end else if (pick < 94) begin
      send_frame(n, 1'b1, 1'b0);
      send_byte(BYTE_ESCAPE);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int lim;
    int goal;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit of 255.
    write_limit(MAX_LEN_RESET);
    // Outside a frame only the start byte matters.
    send_list('{BYTE_END, BYTE_ESCAPE, 8'h00});
    // Good frame with an escaped checksum byte: 0x01 + 0xFF sums to zero.
    send_list('{BYTE_START, 8'h01, BYTE_ESCAPE, 8'h7F, BYTE_END});
    // An empty frame is reported as bad.
    send_list('{BYTE_START, BYTE_END});
    // Restart inside a frame, then restart right after an escape.
    send_list('{BYTE_START, 8'h05, BYTE_START, BYTE_ESCAPE, BYTE_START});
    // Escape followed by the end marker is a frame error.
    send_list('{BYTE_ESCAPE, BYTE_END});
    // Escape followed by another escape is a frame error as well.
    send_list('{BYTE_START, BYTE_ESCAPE, BYTE_ESCAPE});
    // Escaped zero decodes to 0x80; the sum is nonzero so the end is bad.
    send_list('{BYTE_START, BYTE_ESCAPE, 8'h00, BYTE_END});

    // Smallest limit: a one-byte frame fits, a second data byte aborts.
    write_limit(8'd1);
    send_list('{BYTE_START, 8'h00, BYTE_END, BYTE_START, 8'h00, 8'h01});

    // Random phases over several limits, the extremes among them. Two phases
    // run without idling on either side. The two long frames count toward
    // the byte budget of their phase.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: lim = 255;
        1: lim = 1;
        2: lim = $urandom_range(2, 8);
        3: lim = 255;
        4: lim = $urandom_range(9, 40);
        default: lim = $urandom_range(1, 255);
      endcase
      write_limit(8'(lim));
      in_gap_max  = (p == 2 || p == 4) ? 0 : 4;
      out_gap_max = (p == 2 || p == 4) ? 0 : 4;
      goal = sb.frame_bytes + 30;
      if (p == 3) begin
        // A full-length frame ends good with the largest payload length; one
        // byte more trips the limit.
        send_frame(255, 1'b1, 1'b1);
        send_frame(256, 1'b1, 1'b1);
      end
      while (sb.frame_bytes < goal) random_chunk(lim);
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing beat ends up here.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hdl/bsfr_pkg.sv
hdl/bsfr_front.sv
hdl/bsfr_queue.sv
hdl/bsfr_back.sv
hdl/byte_stuffed_frame_receiver_top.sv
tb/tb_byte_stuffed_frame_receiver_top.sv
